/* design/hem_pkg.sv */
// ----------------------------------------------------------------------------
// hem_pkg
// shared widths, types and codes for the hysteresis extrema memory
// ----------------------------------------------------------------------------
package hem_pkg;

  localparam int DEPTH    = 32;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int LEN_W    = $clog2(DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t THRESHOLD_RESET = sample_t'(-10);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_OUT
  } fsm_state_t;

  // what one sample does to the list
  typedef enum logic [2:0] {
    CASE_OFF,
    CASE_TOP,
    CASE_BOTTOM,
    CASE_RISE,
    CASE_FALL,
    CASE_HOLD
  } upd_case_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_CMP,
    CELL_UPD,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    upd_case_t        upd_case;
    logic [LEN_W-1:0] len;
    logic             found;
    logic             append_ok;
  } cell_ctrl_t;

endpackage

/* design/hem_cell.sv */
// ----------------------------------------------------------------------------
// hem_cell
// one list entry: compare against the sample, wipe/write, rotate for readout
// ----------------------------------------------------------------------------
module hem_cell import hem_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] cell_idx,
  input  sample_t          u,
  input  sample_t          next_value,
  input  sample_t          head_value,
  input  logic             wipe_in,
  output logic             wipe_out,
  output logic             first_hit,
  output sample_t          value
);

  sample_t          value_r, value_nxt;
  logic             hit_r, hit_nxt;
  logic             in_len;
  logic             is_tail;
  logic             is_append;
  logic [LEN_W-1:0] pos;

  assign pos       = {1'b0, cell_idx};
  assign in_len    = pos < ctrl.len;
  assign is_tail   = pos == LEN_W'(ctrl.len - LEN_W'(1));
  assign is_append = !ctrl.found && ctrl.append_ok && (pos == ctrl.len);

  // prefix chain: first reached entry of the right parity wins
  assign first_hit = hit_r && !wipe_in;
  assign wipe_out  = wipe_in || hit_r;
  assign value     = value_r;

  always_comb begin
    value_nxt = value_r;
    hit_nxt   = hit_r;
    unique case (ctrl.op)
      CELL_IDLE: ;
      CELL_CMP: begin
        if (cell_idx[0]) begin
          hit_nxt = in_len && (ctrl.upd_case == CASE_FALL) && (value_r >= u);
        end else begin
          hit_nxt = in_len && (ctrl.upd_case == CASE_RISE) && (value_r <= u);
        end
      end
      CELL_UPD: begin
        case (ctrl.upd_case) inside
          CASE_TOP: begin
            if (cell_idx == IDX_W'(0)) value_nxt = u;
          end
          CASE_BOTTOM: begin
            if (cell_idx == IDX_W'(1)) value_nxt = u;
          end
          CASE_RISE, CASE_FALL: begin
            if (first_hit || is_append) value_nxt = u;
          end
          default: ;
        endcase
      end
      CELL_ROT: begin
        if (in_len) value_nxt = is_tail ? head_value : next_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    hit_r   <= hit_nxt;
  end

endmodule

/* design/hysteresis_extrema_memory.sv */
// ----------------------------------------------------------------------------
// hysteresis_extrema_memory
// hysteresis memory kept as a list of alternating extrema with wipe-out
// ----------------------------------------------------------------------------
// order: a taken sample passes S_CMP and S_UPD; S_OUT then gives its beats
// input: a new sample is taken only in S_IDLE, after the last result beat of
//   the previous one; the readout gives one beat per list entry (one while
//   off), at most DEPTH, rotating the cell chain one entry per result beat
// reset: synchronous active-low; system off, list empty, threshold -10;
//   stored entries are not cleared
// ----------------------------------------------------------------------------
module hysteresis_extrema_memory import hem_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wr_en,
  input  sample_t          cfg_wr_data,
  // sample input
  input  logic             in_valid,
  output logic             in_stall,
  input  sample_t          in_sample,
  // result beats, one per list entry
  output logic             out_valid,
  input  logic             out_stall,
  output sample_t          out_entry_value,
  output logic [IDX_W-1:0] out_entry_index,
  output logic             out_is_maximum,
  output logic [LEN_W-1:0] out_entry_count,
  output logic             out_system_on,
  output logic             out_overflow,
  output logic             out_last
);

  // control state
  fsm_state_t       state_r, state_nxt;
  sample_t          thr_r;
  logic             on_r, on_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  upd_case_t        case_r, case_cmb;

  // payload
  sample_t          u_r;
  sample_t          back_r, back_nxt;   // last list entry, kept aside

  // cell chain
  cell_ctrl_t       cell_ctrl;
  sample_t          vals [DEPTH];
  logic             wipe_chain [DEPTH+1];
  logic [DEPTH-1:0] first_vec;
  logic             found;
  logic             append_ok;
  logic [LEN_W-1:0] hit_len;
  sample_t          gmin;

  logic             in_beat, out_beat, last_beat;

  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign found     = wipe_chain[DEPTH];
  assign append_ok = len_r < LEN_W'(DEPTH);

  // ---------------- cell chain ----------------
  assign wipe_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sample_t next_v;
    if (g < DEPTH - 1) begin : g_mid
      assign next_v = vals[g+1];
    end else begin : g_end
      assign next_v = vals[0];   // last cell only ever wraps to the head
    end

    hem_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .cell_idx   (IDX_W'(g)),
      .u          (u_r),
      .next_value (next_v),
      .head_value (vals[0]),
      .wipe_in    (wipe_chain[g]),
      .wipe_out   (wipe_chain[g+1]),
      .first_hit  (first_vec[g]),
      .value      (vals[g])
    );
  end

  // new length when an entry gets wiped: position of the winning cell plus one
  always_comb begin
    hit_len = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (first_vec[k]) hit_len = hit_len | LEN_W'(k + 1);
    end
  end

  // ---------------- classify the sample ----------------
  // global minimum is the second entry, or the only entry if just one
  assign gmin = (len_r >= LEN_W'(2)) ? vals[1] : vals[0];

  always_comb begin
    if (!on_r) begin
      case_cmb = (u_r > thr_r) ? CASE_TOP : CASE_OFF;   // turn-on acts like a new top
    end else if (u_r >= vals[0]) begin
      case_cmb = CASE_TOP;
    end else if (u_r <= gmin) begin
      case_cmb = CASE_BOTTOM;
    end else if (u_r > back_r) begin
      case_cmb = CASE_RISE;
    end else if (u_r < back_r) begin
      case_cmb = CASE_FALL;
    end else begin
      case_cmb = CASE_HOLD;   // repeat of the last entry
    end
  end

  // ---------------- fsm: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_OUT;
      S_OUT:  if (out_beat && last_beat) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- fsm: outputs ----------------
  always_comb begin
    in_stall            = 1'b1;
    out_valid           = 1'b0;
    cell_ctrl.op        = CELL_IDLE;
    cell_ctrl.upd_case  = case_r;
    cell_ctrl.len       = len_r;
    cell_ctrl.found     = found;
    cell_ctrl.append_ok = append_ok;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_CMP: begin
        cell_ctrl.op       = CELL_CMP;
        cell_ctrl.upd_case = case_cmb;
      end
      S_UPD:  cell_ctrl.op = CELL_UPD;
      S_OUT: begin
        out_valid = 1'b1;
        // rotate only while a real list is read out
        if (out_beat && case_r != CASE_OFF) cell_ctrl.op = CELL_ROT;
      end
      default: ;
    endcase
  end

  // ---------------- list bookkeeping ----------------
  always_comb begin
    on_nxt   = on_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    back_nxt = back_r;
    idx_nxt  = idx_r;
    if (state_r == S_UPD) begin
      ovf_nxt = 1'b0;
      idx_nxt = '0;
      case (case_r) inside
        CASE_TOP: begin
          on_nxt   = 1'b1;
          len_nxt  = LEN_W'(1);
          back_nxt = u_r;
        end
        CASE_BOTTOM: begin
          len_nxt  = LEN_W'(2);
          back_nxt = u_r;
        end
        CASE_RISE, CASE_FALL: begin
          if (found) begin
            len_nxt  = hit_len;
            back_nxt = u_r;
          end else if (append_ok) begin
            len_nxt  = LEN_W'(len_r + LEN_W'(1));
            back_nxt = u_r;
          end else begin
            ovf_nxt = 1'b1;   // list full, push dropped
          end
        end
        default: ;
      endcase
    end else if (out_beat) begin
      idx_nxt = IDX_W'(idx_r + IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thr_r   <= THRESHOLD_RESET;
      on_r    <= 1'b0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      case_r  <= CASE_OFF;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      on_r    <= on_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      if (state_r == S_CMP) case_r <= case_cmb;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) u_r <= in_sample;
    back_r <= back_nxt;
  end

  // ---------------- result beat ----------------
  // head cell always holds the entry at idx_r during readout
  assign last_beat = (case_r == CASE_OFF) ||
                     ({1'b0, idx_r} == LEN_W'(len_r - LEN_W'(1)));

  always_comb begin
    if (case_r == CASE_OFF) begin
      out_entry_value = '0;
      out_entry_index = '0;
      out_is_maximum  = 1'b0;
      out_entry_count = '0;
    end else begin
      out_entry_value = vals[0];
      out_entry_index = idx_r;
      out_is_maximum  = !idx_r[0];
      out_entry_count = len_r;
    end
  end

  assign out_system_on = on_r;
  assign out_overflow  = ovf_r;
  assign out_last      = last_beat;

  // ---------------- assertions ----------------
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(DEPTH))
    else $error("list length beyond depth");

  a_one_winner: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |-> $onehot0(first_vec))
    else $error("more than one cell won the wipe");

  a_on_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    on_r |=> on_r)
    else $error("system switched off after turn-on");

  a_readout_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && case_r != CASE_OFF |-> ({1'b0, idx_r} < len_r))
    else $error("readout index past list end");

  a_off_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !on_r |-> len_r == '0)
    else $error("list holds entries while off");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hysteresis_extrema_memory: a clocked driver feeds
// samples from a queue, a clocked monitor predicts the extrema list for every
// accepted sample and checks each result beat against the oldest expectation
// ----------------------------------------------------------------------------
module tb import hem_pkg::*; ();

  localparam int TIMEOUT_CYCLES = 500000;
  localparam int DRAIN_PAUSE    = 8;
  localparam int RANDOM_ITEMS   = 105;    // per idling phase, three phases

  // one expected result beat
  typedef struct packed {
    sample_t          value;
    logic [IDX_W-1:0] index;
    logic             is_max;
    logic [LEN_W-1:0] count;
    logic             on;
    logic             ovf;
    logic             last;
  } entry_beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  sample_t          cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  sample_t          in_sample;
  logic             out_valid;
  logic             out_stall;
  sample_t          out_entry_value;
  logic [IDX_W-1:0] out_entry_index;
  logic             out_is_maximum;
  logic [LEN_W-1:0] out_entry_count;
  logic             out_system_on;
  logic             out_overflow;
  logic             out_last;

  hysteresis_extrema_memory DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_value (out_entry_value),
    .out_entry_index (out_entry_index),
    .out_is_maximum  (out_is_maximum),
    .out_entry_count (out_entry_count),
    .out_system_on   (out_system_on),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

  // samples waiting to be driven, and result beats waiting to arrive
  sample_t     sample_queue[$];
  entry_beat_t expected_entries[$];

  // shadow copy of the block state
  sample_t     shadow_list[DEPTH];
  int          shadow_len;
  logic        shadow_on;
  sample_t     shadow_threshold;

  int          send_idle_pct;
  int          stall_pct;
  int          fail_count;
  int          cycle_count;
  int          queued_items;
  logic        in_beat_taken;

  // --------------------------------------------------------------------------
  // clock and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction: apply one sample to the shadow list and queue its beats
  // --------------------------------------------------------------------------
  task automatic update_extrema(input sample_t u);
    sample_t     first;
    sample_t     gmin;
    sample_t     back;
    logic        rising;
    logic        found;
    logic        push_ok;
    int          i;
    entry_beat_t beat;
    push_ok = 1'b1;
    if (!shadow_on) begin
      if (u > shadow_threshold) begin
        // switch on with a one-entry list
        shadow_on      = 1'b1;
        shadow_list[0] = u;
        shadow_len     = 1;
      end else begin
        // still off: a single all-zero beat marked last
        beat      = '0;
        beat.last = 1'b1;
        expected_entries = {expected_entries, beat};
        return;
      end
    end else begin
      first = shadow_list[0];
      gmin  = (shadow_len >= 2) ? shadow_list[1] : first;
      back  = shadow_list[shadow_len-1];
      if (u >= first) begin
        // new global maximum wipes everything
        shadow_list[0] = u;
        shadow_len     = 1;
      end else if (u <= gmin) begin
        // new global minimum keeps only the global maximum
        shadow_list[1] = u;
        shadow_len     = 2;
      end else if (u != back) begin
        // rising wipes from the first maximum reached, falling from the
        // first minimum reached; also when moving on in the same direction
        rising = (u > back);
        found  = 1'b0;
        for (i = rising ? 0 : 1; i < shadow_len && !found; i += 2) begin
          if (rising ? (shadow_list[i] <= u) : (shadow_list[i] >= u)) begin
            shadow_list[i] = u;
            shadow_len     = i + 1;
            found          = 1'b1;
          end
        end
        if (!found) begin
          if (shadow_len < DEPTH) begin
            shadow_list[shadow_len] = u;
            shadow_len++;
          end else begin
            push_ok = 1'b0;  // full list drops the push
          end
        end
      end
    end
    // the whole list goes out, oldest entry first
    for (i = 0; i < shadow_len; i++) begin
      beat.value  = shadow_list[i];
      beat.index  = IDX_W'(i);
      beat.is_max = (i % 2 == 0);
      beat.count  = LEN_W'(shadow_len);
      beat.on     = 1'b1;
      beat.ovf    = !push_ok;
      beat.last   = (i == shadow_len - 1);
      expected_entries = {expected_entries, beat};
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: changes inputs on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // a held beat stays put until the monitor has seen it taken
      if (!in_valid || in_beat_taken) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_beat_taken = 1'b0;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    entry_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        update_extrema(in_sample);
        in_beat_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_entries.size() == 0) begin
          $error("result beat with no expectation: entry_value %0d index %0d",
                 out_entry_value, out_entry_index);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          compare_field("entry_value", want.value,  out_entry_value);
          compare_field("entry_index", want.index,  out_entry_index);
          compare_field("is_maximum",  want.is_max, out_is_maximum);
          compare_field("entry_count", want.count,  out_entry_count);
          compare_field("system_on",   want.on,     out_system_on);
          compare_field("overflow",    want.ovf,    out_overflow);
          compare_field("last",        want.last,   out_last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_sample(input int v);
    sample_queue = {sample_queue, sample_t'(v)};
    queued_items++;
  endtask

  // wait until every sample is taken and every result beat has arrived
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || expected_entries.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // threshold write, only while the block is idle
  task automatic write_threshold(input sample_t v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_threshold = v;
  endtask

  // well-formed converging oscillation from the full-scale extremes; each
  // new peak lands inside the previous ones so the list keeps growing
  task automatic add_chain(input int n);
    int hi;
    int lo;
    int step;
    int k;
    hi = 32767;
    lo = -32768;
    queue_sample(hi);
    queue_sample(lo);
    for (k = 0; k < n; k++) begin
      if (hi - lo < 4) break;
      step = $urandom_range(1, ((hi - lo) / 8 > 1) ? (hi - lo) / 8 : 1);
      if (k % 2 == 0) begin
        hi = hi - step;
        queue_sample(hi);
      end else begin
        lo = lo + step;
        queue_sample(lo);
      end
      if ($urandom_range(9) == 0) queue_sample((k % 2 == 0) ? hi : lo);  // repeat: hold
    end
  endtask

  task automatic add_random(input int n);
    int goal;
    goal = queued_items + n;
    while (queued_items < goal) begin
      case ($urandom_range(9))
        0, 1:    queue_sample($urandom_range(65535) - 32768);      // full-scale noise
        2:       queue_sample($urandom_range(100) - 50);           // noise near zero
        3:       add_chain($urandom_range(30, 36));                // runs into a full list
        default: add_chain($urandom_range(2, 16));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_sample        = '0;
    out_stall        = 1'b0;
    in_beat_taken    = 1'b0;
    fail_count       = 0;
    queued_items     = 0;
    shadow_len       = 0;
    shadow_on        = 1'b0;
    shadow_threshold = THRESHOLD_RESET;
    send_idle_pct    = 30;
    stall_pct        = 61;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // off: reset threshold is not exceeded by equal or lowest samples
    queue_sample(-10);
    queue_sample(-32768);
    drain();
    // highest threshold: nothing can exceed it
    write_threshold(sample_t'(32767));
    queue_sample(32767);
    drain();
    // lowest threshold: the lowest sample is still not above it
    write_threshold(sample_t'(-32768));
    queue_sample(-32768);
    drain();
    // equal stays off, one above switches on
    write_threshold(sample_t'(100));
    queue_sample(100);
    queue_sample(101);
    drain();

    // on: top, bottom, rise, hold, fall, same-direction wipes, equal extremes
    queue_sample(32767);
    queue_sample(-32768);
    queue_sample(0);
    queue_sample(0);
    queue_sample(-100);
    queue_sample(50);
    queue_sample(60);
    queue_sample(-200);
    queue_sample(-150);
    queue_sample(-180);
    queue_sample(-190);
    queue_sample(32767);
    queue_sample(-32768);
    queue_sample(-32767);
    drain();

    // random part over three idling profiles
    write_threshold(sample_t'($urandom_range(65535)));
    add_random(RANDOM_ITEMS);
    drain();

    send_idle_pct = 61;
    stall_pct     = 30;
    write_threshold(sample_t'($urandom_range(65535)));
    add_random(RANDOM_ITEMS);
    drain();

    send_idle_pct = 0;
    stall_pct     = 0;
    write_threshold(THRESHOLD_RESET);
    add_random(RANDOM_ITEMS);
    drain();

    if (fail_count == 0 && expected_entries.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/hem_pkg.sv
design/hem_cell.sv
design/hysteresis_extrema_memory.sv
dv/tb.sv
